### design/pcmf_pkg.sv
// Shared types and constants for the PCM format to fixed-point sample converter.
`timescale 1ns / 1ps
package pcmf_pkg;
	localparam int OUT_FRAC_BITS = 16;
	localparam logic [5:0] FMT_SILENCE = 6'd1;
	localparam logic [5:0] FMT_F32A = 6'd16;
	localparam logic [5:0] FMT_F64A = 6'd17;
	localparam logic [5:0] FMT_F32B = 6'd20;
	localparam logic [5:0] FMT_F64B = 6'd24;
	localparam logic [5:0] FMT_F80A = 6'd26;
	localparam logic [5:0] FMT_F80B = 6'd28;
	localparam logic [5:0] FMT_F80C = 6'd32;
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_ORDER = 2'd1;
	localparam logic [1:0] REG_CH_IN = 2'd2;
	localparam logic [1:0] REG_CH_OUT = 2'd3;

	typedef enum logic [1:0] {KIND_ZERO, KIND_INT, KIND_FLOAT} kind_t;

	// Decoded number: value = +/- mant * 2^(shift) ; special forces clamp.
	typedef struct packed {
		logic [63:0] mant;
		logic signed [16:0] shift;
		logic neg;
		logic special;
	} dec_t;

	typedef struct packed {
		kind_t kind;
		logic [3:0] nbytes;
		logic flip;
		logic big;
	} fmt_t;
endpackage

### design/pcm_format_to_fixed_sample_unit.sv
// Top level of the PCM format to fixed-point sample converter.
// Converts one stereo frame per clock while the output is not stalled: stage one
// orders bytes and decodes fields, stage two aligns and saturates, stage three
// maps channels, and an output register holds the result. A stall at the output
// holds each full stage that has no empty stage ahead of it.
`timescale 1ns / 1ps
module pcm_format_to_fixed_sample_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [63:0] left_raw_low,
	input logic [15:0] left_raw_high,
	input logic [63:0] right_raw_low,
	input logic [15:0] right_raw_high,
	input logic frame_last,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] left_sample,
	output logic signed [31:0] right_sample,
	output logic saturated,
	output logic format_error,
	output logic last_out,
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [5:0] cfg_data
);
	import pcmf_pkg::*;
	logic [5:0] format_code_q;
	logic [1:0] byte_order_q, ch_in_q, ch_out_q;
	fmt_t fmt;
	logic valid_fmt, err;
	always_comb begin
		fmt = '0;
		fmt.big = byte_order_q[0];
		valid_fmt = 1'b1;
		if (format_code_q >= 6'd2 && format_code_q <= 6'd9) begin
			fmt.kind = KIND_INT;
			fmt.nbytes = 4'(((format_code_q - 6'd2) >> 1) + 6'd1);
			fmt.flip = ~format_code_q[0];
		end else if (format_code_q == FMT_F32A || format_code_q == FMT_F32B ||
			format_code_q == FMT_F64A || format_code_q == FMT_F64B ||
			format_code_q == FMT_F80A || format_code_q == FMT_F80B ||
			format_code_q == FMT_F80C) fmt.kind = KIND_FLOAT;
		else if (format_code_q == FMT_SILENCE) fmt.kind = KIND_ZERO;
		else valid_fmt = 1'b0;
		err = !valid_fmt || ch_in_q == 2'd0 || ch_in_q == 2'd3
			|| ch_out_q == 2'd0 || ch_out_q == 2'd3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_code_q <= 6'd5;
			byte_order_q <= 2'd0;
			ch_in_q <= 2'd2;
			ch_out_q <= 2'd2;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_FORMAT: format_code_q <= cfg_data;
				REG_ORDER: byte_order_q <= cfg_data[1:0];
				REG_CH_IN: ch_in_q <= cfg_data[1:0];
				REG_CH_OUT: ch_out_q <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic v_s1, v_s2, v_s3;
	logic adv_s3, adv_s2, adv_s1, adv_in;
	assign adv_s3 = !out_valid || !out_stall;
	assign adv_s2 = !v_s3 || adv_s3;
	assign adv_s1 = !v_s2 || adv_s2;
	assign adv_in = !v_s1 || adv_s1;
	assign in_stall = !adv_in;

	dec_t dl, dr, dl_s1, dr_s1;
	logic last_s1, err_s1, last_s2, err_s2;
	pcmf_decode u_dl (.raw_low(left_raw_low), .raw_high(left_raw_high),
		.fmt_code(format_code_q), .fmt(fmt), .dec(dl));
	pcmf_decode u_dr (.raw_low(right_raw_low), .raw_high(right_raw_high),
		.fmt_code(format_code_q), .fmt(fmt), .dec(dr));

	logic signed [32:0] ql, qr, ql_s2, qr_s2;
	logic sl, sr, sat_s2;
	pcmf_scale u_sl (.dec(dl_s1), .q(ql), .sat(sl));
	pcmf_scale u_sr (.dec(dr_s1), .q(qr), .sat(sr));

	logic signed [31:0] l_s3, r_s3;
	logic sat_s3, err_s3, last_s3;
	logic signed [33:0] sum;
	logic signed [31:0] lm, rm;
	always_comb begin
		sum = 34'(ql_s2) + 34'(qr_s2);
		lm = ql_s2[31:0];
		rm = (ch_in_q == 2'd2) ? qr_s2[31:0] : ql_s2[31:0];
		if (ch_out_q == 2'd1) begin
			if (ch_in_q == 2'd2) lm = 32'((sum + 34'(sum[33])) >>> 1);
			rm = '0;
		end
		if (err_s2) begin
			lm = '0;
			rm = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; out_valid <= 1'b0;
		end else begin
			if (adv_in) v_s1 <= in_valid;
			if (adv_s1) v_s2 <= v_s1;
			if (adv_s2) v_s3 <= v_s2;
			if (adv_s3) out_valid <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_in) begin
			dl_s1 <= dl;
			// mono input ignores the right raw bytes
			dr_s1 <= (ch_in_q == 2'd2) ? dr : '0;
			last_s1 <= frame_last;
			err_s1 <= err;
		end
		if (adv_s1) begin
			ql_s2 <= ql; qr_s2 <= qr;
			sat_s2 <= !err_s1 && (sl || sr);
			err_s2 <= err_s1; last_s2 <= last_s1;
		end
		if (adv_s2) begin
			l_s3 <= lm; r_s3 <= rm;
			sat_s3 <= sat_s2; err_s3 <= err_s2; last_s3 <= last_s2;
		end
		if (adv_s3) begin
			left_sample <= l_s3; right_sample <= r_s3;
			saturated <= sat_s3; format_error <= err_s3; last_out <= last_s3;
		end
	end
endmodule

### design/pcmf_decode.sv
// Stage one: byte ordering and field decode of one channel into mantissa and scale.
`timescale 1ns / 1ps
module pcmf_decode (
	input logic [63:0] raw_low,
	input logic [15:0] raw_high,
	input logic [5:0] fmt_code,
	input pcmf_pkg::fmt_t fmt,
	output pcmf_pkg::dec_t dec
);
	import pcmf_pkg::*;
	logic [7:0] b [10];
	logic [63:0] w8, w4, m80;
	logic [15:0] se;
	logic [31:0] iv;
	logic [31:0] s;
	always_comb begin
		for (int i = 0; i < 8; i++) b[i] = raw_low[8*i +: 8];
		b[8] = raw_high[7:0];
		b[9] = raw_high[15:8];
		w8 = '0; w4 = '0; m80 = '0; iv = '0;
		for (int i = 0; i < 8; i++) begin
			w8[8*i +: 8] = fmt.big ? b[7-i] : b[i];
			m80[8*i +: 8] = fmt.big ? b[9-i] : b[i];
		end
		for (int i = 0; i < 4; i++) begin
			w4[8*i +: 8] = fmt.big ? b[3-i] : b[i];
			// left-aligned integer: byte k of n lands at bits from the top
			if (i < 32'(fmt.nbytes))
				iv[31-8*i -: 8] = fmt.big ? b[i] : b[32'(fmt.nbytes)-1-i];
		end
		se = fmt.big ? {b[0], b[1]} : {b[9], b[8]};
		s = iv ^ {fmt.flip, 31'd0};
		dec = '0;
		if (fmt.kind == KIND_INT) begin
			dec.neg = s[31];
			dec.mant = {32'd0, s[31] ? 32'(0 - s) : s};
			dec.shift = 17'(OUT_FRAC_BITS - 16);
		end else if (fmt.kind == KIND_FLOAT) begin
			if (fmt_code == FMT_F32A || fmt_code == FMT_F32B) begin
				dec.neg = w4[31];
				dec.special = w4[30:23] == 8'hFF;
				dec.mant = {40'd0, w4[30:23] != 0, w4[22:0]};
				dec.shift = (w4[30:23] == 0) ? 17'(OUT_FRAC_BITS - 149)
					: 17'(signed'({9'd0, w4[30:23]})) - 17'(150 - OUT_FRAC_BITS);
			end else if (fmt_code == FMT_F64A || fmt_code == FMT_F64B) begin
				dec.neg = w8[63];
				dec.special = w8[62:52] == 11'h7FF;
				dec.mant = {11'd0, w8[62:52] != 0, w8[51:0]};
				dec.shift = (w8[62:52] == 0) ? 17'(OUT_FRAC_BITS - 1074)
					: 17'(signed'({6'd0, w8[62:52]})) - 17'(1075 - OUT_FRAC_BITS);
			end else begin
				dec.neg = se[15];
				dec.special = se[14:0] == 15'h7FFF;
				dec.mant = m80;
				dec.shift = (se[14:0] == 0) ? 17'(OUT_FRAC_BITS - 16445)
					: 17'(signed'({2'd0, se[14:0]})) - 17'(16446 - OUT_FRAC_BITS);
			end
		end
	end
endmodule

### design/pcmf_scale.sv
// Stage two: shift a decoded value onto the fixed-point grid with saturation.
`timescale 1ns / 1ps
module pcmf_scale (
	input pcmf_pkg::dec_t dec,
	output logic signed [32:0] q,
	output logic sat
);
	import pcmf_pkg::*;
	logic [63:0] mag;
	logic [32:0] lim;
	logic [6:0] r;
	always_comb begin
		lim = dec.neg ? 33'h080000000 : 33'h07FFFFFFF;
		mag = '0;
		sat = 1'b0;
		r = '0;
		if (dec.special) sat = 1'b1;
		else if (dec.mant != 0) begin
			if (dec.shift >= 0) begin
				if (dec.shift > 31) sat = 1'b1;
				else begin
					mag = dec.mant << dec.shift[4:0];
					if ((dec.mant >> (6'd32 - {1'b0, dec.shift[4:0]})) != 0
						|| mag > {31'd0, lim}) sat = 1'b1;
				end
			end else begin
				if (dec.shift > -17'sd64) begin
					r = 7'(0 - dec.shift);
					mag = dec.mant >> r[5:0];
				end
				if (mag > {31'd0, lim}) sat = 1'b1;
			end
		end
		if (sat) mag = {31'd0, lim};
		q = dec.neg ? -signed'(mag[32:0]) : signed'(mag[32:0]);
	end
endmodule
